/* rtl/eilc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eilc_pkg
// Shared types and constants for the edge interrupt line controller.
// ----------------------------------------------------------------------------
package eilc_pkg;

   localparam int LINE_WIDTH  = 16;
   localparam int GROUP_COUNT = 3;

   localparam logic [1:0] CMD_SAMPLE = 2'd0;
   localparam logic [1:0] CMD_WRITE  = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;

   localparam logic [1:0] REG_MASK    = 2'd0;
   localparam logic [1:0] REG_RISING  = 2'd1;
   localparam logic [1:0] REG_FALLING = 2'd2;
   localparam logic [1:0] REG_PENDING = 2'd3;

   localparam logic [LINE_WIDTH-1:0] GROUP0_LINES = 16'h0003;
   localparam logic [LINE_WIDTH-1:0] GROUP1_LINES = 16'h000c;
   localparam logic [LINE_WIDTH-1:0] GROUP2_LINES = 16'hfff0;

   // per-line view of one request
   typedef struct packed {
      logic       accept;
      logic [1:0] command;
      logic [1:0] reg_select;
      logic       write_bit;
      logic       level_bit;
   } lane_req_type;

   // what one line reports back
   typedef struct packed {
      logic read_bit;
      logic active;
   } lane_rsp_type;

endpackage

/* rtl/eilc_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eilc_lane
// State and edge detection for a single interrupt line.
// ----------------------------------------------------------------------------
module eilc_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  eilc_pkg::lane_req_type lane_req,
   output eilc_pkg::lane_rsp_type lane_rsp
);

   logic prev_ff, prev_in;
   logic mask_ff, mask_in;
   logic rise_ff, rise_in;
   logic fall_ff, fall_in;
   logic pend_ff, pend_in;

   always_comb begin
      prev_in = prev_ff;
      mask_in = mask_ff;
      rise_in = rise_ff;
      fall_in = fall_ff;
      pend_in = pend_ff;
      lane_rsp.read_bit = 1'b0;
      if (lane_req.accept) begin
         unique case (lane_req.command)
            eilc_pkg::CMD_SAMPLE: begin
               pend_in = pend_ff
                  | (lane_req.level_bit & ~prev_ff & rise_ff)
                  | (~lane_req.level_bit & prev_ff & fall_ff);
               prev_in = lane_req.level_bit;
            end
            eilc_pkg::CMD_WRITE: begin
               unique case (lane_req.reg_select)
                  eilc_pkg::REG_MASK:    mask_in = lane_req.write_bit;
                  eilc_pkg::REG_RISING:  rise_in = lane_req.write_bit;
                  eilc_pkg::REG_FALLING: fall_in = lane_req.write_bit;
                  default:               pend_in = pend_ff & ~lane_req.write_bit;
               endcase
            end
            eilc_pkg::CMD_READ: begin
               unique case (lane_req.reg_select)
                  eilc_pkg::REG_MASK:    lane_rsp.read_bit = mask_ff;
                  eilc_pkg::REG_RISING:  lane_rsp.read_bit = rise_ff;
                  eilc_pkg::REG_FALLING: lane_rsp.read_bit = fall_ff;
                  default:               lane_rsp.read_bit = pend_ff;
               endcase
            end
            default: ;
         endcase
      end
      lane_rsp.active = pend_in & mask_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= 1'b0;
         mask_ff <= 1'b0;
         rise_ff <= 1'b0;
         fall_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         prev_ff <= prev_in;
         mask_ff <= mask_in;
         rise_ff <= rise_in;
         fall_ff <= fall_in;
         pend_ff <= pend_in;
      end
   end

endmodule

/* rtl/eilc_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eilc_merge
// Gathers lane results into read data and grouped interrupts, and holds
// the result register.
// ----------------------------------------------------------------------------
module eilc_merge (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          load,
   input  logic                                          drain,
   input  eilc_pkg::lane_rsp_type [eilc_pkg::LINE_WIDTH-1:0] lane_rsp,
   output logic                                          valid,
   output logic [eilc_pkg::LINE_WIDTH-1:0]               read_value,
   output logic [eilc_pkg::GROUP_COUNT-1:0]              irq_groups
);

   logic                               valid_ff, valid_in;
   logic [eilc_pkg::LINE_WIDTH-1:0]    read_ff, read_in;
   logic [eilc_pkg::GROUP_COUNT-1:0]   groups_ff, groups_in;
   logic [eilc_pkg::LINE_WIDTH-1:0]    active;

   always_comb begin
      for (int i = 0; i < eilc_pkg::LINE_WIDTH; i++) begin
         read_in[i] = lane_rsp[i].read_bit;
         active[i]  = lane_rsp[i].active;
      end
      groups_in[0] = |(active & eilc_pkg::GROUP0_LINES);
      groups_in[1] = |(active & eilc_pkg::GROUP1_LINES);
      groups_in[2] = |(active & eilc_pkg::GROUP2_LINES);
      valid_in = load | (valid_ff & ~drain);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         read_ff   <= read_in;
         groups_ff <= groups_in;
      end
   end

   assign valid      = valid_ff;
   assign read_value = read_ff;
   assign irq_groups = groups_ff;

endmodule

/* rtl/edge_interrupt_line_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_interrupt_line_controller
// Edge-triggered external interrupt controller with grouped outputs.
// ----------------------------------------------------------------------------
// Each request is a line sample, a register write or a register read and
// gives exactly one response in the next cycle; one request is taken every
// cycle while the response register is free or being drained. Each line has
// its own lane holding level, mask, edge selects and pending bit; the merge
// stage gathers the lanes into read data and ORs them into the three interrupt
// groups (lines 0-1, 2-3, 4-15), taken after the request's update.
module edge_interrupt_line_controller #(
   parameter int LINE_COUNT = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // write_value[15:0], line_levels[31:16]
   input  logic [3:0]  req_tuser,   // command[1:0], reg_select[3:2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // read_value[15:0], irq_groups[18:16], zero
);

   localparam int LaneCount = (LINE_COUNT < eilc_pkg::LINE_WIDTH)
                              ? LINE_COUNT : eilc_pkg::LINE_WIDTH;

   logic                                          accept;
   logic                                          drain;
   logic [eilc_pkg::LINE_WIDTH-1:0]               read_value;
   logic [eilc_pkg::GROUP_COUNT-1:0]              irq_groups;
   eilc_pkg::lane_rsp_type [eilc_pkg::LINE_WIDTH-1:0] lane_rsp;

   assign drain      = rsp_tvalid & rsp_tready;
   assign req_tready = ~rsp_tvalid | rsp_tready;
   assign accept     = req_tvalid & req_tready;

   for (genvar i = 0; i < eilc_pkg::LINE_WIDTH; i++) begin : g_lane
      if (i < LaneCount) begin : g_used
         eilc_pkg::lane_req_type lane_req;
         assign lane_req.accept     = accept;
         assign lane_req.command    = req_tuser[1:0];
         assign lane_req.reg_select = req_tuser[3:2];
         assign lane_req.write_bit  = req_tdata[i];
         assign lane_req.level_bit  = req_tdata[eilc_pkg::LINE_WIDTH + i];
         eilc_lane u_lane (
            .clock    (clock),
            .reset    (reset),
            .lane_req (lane_req),
            .lane_rsp (lane_rsp[i])
         );
      end else begin : g_unused
         assign lane_rsp[i] = '0;
      end
   end

   eilc_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .drain      (drain),
      .lane_rsp   (lane_rsp),
      .valid      (rsp_tvalid),
      .read_value (read_value),
      .irq_groups (irq_groups)
   );

   assign rsp_tdata = {5'd0, irq_groups, read_value};

   ast_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid)
      else $error("accepted request produced no response");

   ast_no_read_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser[1:0] != eilc_pkg::CMD_READ) |=> rsp_tdata[15:0] == 16'd0)
      else $error("non-read response carries read data");

   ast_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("response changed while stalled");

   ast_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:19] == 5'd0)
      else $error("response padding not zero");

endmodule

/* bench/edge_interrupt_line_controller_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_interrupt_line_controller_tb
// Self-checking bench for the 16-line edge interrupt controller.
// ----------------------------------------------------------------------------
// Requests (line samples, register writes and reads, unused commands) are
// queued by the stimulus process and offered by a clocked driver. Every
// accepted request runs through a local model of the lane registers, which
// queues the expected read data and interrupt groups. The monitor takes each
// response in order and compares it field by field. Both sides stall at
// random in two phases; a third has one long response hold-off; all drain.
module edge_interrupt_line_controller_tb;

   localparam int          LINE_COUNT  = 16;
   localparam logic [15:0] LINE_ENABLE = (LINE_COUNT >= 16) ? 16'hffff
                                         : 16'((1 << LINE_COUNT) - 1);
   localparam logic [1:0]  CMD_UNUSED  = 2'd3;
   localparam int          HOLD_CYCLES = 80;
   localparam int          TAIL_CYCLES = 20;
   localparam int          CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [1:0]  command;
      logic [1:0]  reg_select;
      logic [15:0] write_value;
      logic [15:0] line_levels;
   } line_req_type;

   typedef struct packed {
      logic [15:0] read_value;
      logic [2:0]  irq_groups;
   } line_rsp_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;  // write_value[15:0], line_levels[31:16]
   logic [3:0]  req_tuser  = '0;  // command[1:0], reg_select[3:2]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // read_value[15:0], irq_groups[18:16], zero

   line_req_type request_q[$];
   line_rsp_type expected_rsp_q[$];
   line_req_type drive_item;

   // model copy of the lane registers
   logic [15:0] prev_levels = '0;
   logic [15:0] mask_reg    = '0;
   logic [15:0] rise_sel    = '0;
   logic [15:0] fall_sel    = '0;
   logic [15:0] pend_reg    = '0;

   int          send_idle_pct = 27;
   int          recv_idle_pct = 81;
   int          hold_seq      = 0;
   int          hold_seen     = 0;
   int          hold_count    = 0;
   int          error_count   = 0;
   int          cycle_count   = 0;
   logic [15:0] stim_levels   = '0;

   edge_interrupt_line_controller #(
      .LINE_COUNT(LINE_COUNT)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   // applies one request to the model and returns the response it yields
   function automatic line_rsp_type apply_request(line_req_type r);
      logic [15:0]  wv;
      logic [15:0]  lv;
      logic [15:0]  active;
      line_rsp_type rsp;
      wv  = r.write_value & LINE_ENABLE;
      lv  = r.line_levels & LINE_ENABLE;
      rsp = '0;
      case (r.command)
         eilc_pkg::CMD_SAMPLE: begin
            pend_reg    = (pend_reg | (lv & ~prev_levels & rise_sel)
                           | (~lv & prev_levels & fall_sel)) & LINE_ENABLE;
            prev_levels = lv;
         end
         eilc_pkg::CMD_WRITE: begin
            case (r.reg_select)
               eilc_pkg::REG_MASK:    mask_reg = wv;
               eilc_pkg::REG_RISING:  rise_sel = wv;
               eilc_pkg::REG_FALLING: fall_sel = wv;
               default:               pend_reg = pend_reg & ~wv;
            endcase
         end
         eilc_pkg::CMD_READ: begin
            case (r.reg_select)
               eilc_pkg::REG_MASK:    rsp.read_value = mask_reg;
               eilc_pkg::REG_RISING:  rsp.read_value = rise_sel;
               eilc_pkg::REG_FALLING: rsp.read_value = fall_sel;
               default:               rsp.read_value = pend_reg;
            endcase
         end
         default: ;
      endcase
      active = pend_reg & mask_reg;
      rsp.irq_groups = {|(active & eilc_pkg::GROUP2_LINES),
                        |(active & eilc_pkg::GROUP1_LINES),
                        |(active & eilc_pkg::GROUP0_LINES)};
      return rsp;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      error_count++;
   endtask

   task automatic push_req(input logic [1:0] cmd, input logic [1:0] sel,
                           input logic [15:0] wv, input logic [15:0] lv);
      line_req_type r;
      r.command     = cmd;
      r.reg_select  = sel;
      r.write_value = wv;
      r.line_levels = lv;
      request_q.push_back(r);
   endtask

   // mostly samples drifting a few lines at a time, with register traffic
   task automatic push_random(input int count);
      int          roll;
      logic [15:0] wv;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         case ($urandom_range(0, 4))
            0:       wv = 16'hffff;
            1:       wv = 16'h0000;
            default: wv = 16'($urandom);
         endcase
         if (roll < 55) begin
            if ($urandom_range(0, 9) == 0)
               stim_levels = 16'($urandom);
            else
               stim_levels = stim_levels ^ 16'($urandom & $urandom);
            push_req(eilc_pkg::CMD_SAMPLE, 2'($urandom), wv, stim_levels);
         end else if (roll < 78) begin
            push_req(eilc_pkg::CMD_WRITE, 2'($urandom), wv, 16'($urandom));
         end else if (roll < 95) begin
            push_req(eilc_pkg::CMD_READ, 2'($urandom), wv, 16'($urandom));
         end else begin
            push_req(CMD_UNUSED, 2'($urandom), wv, 16'($urandom));
         end
      end
   endtask

   task automatic wait_drained();
      while (request_q.size() != 0 || req_tvalid || expected_rsp_q.size() != 0)
         @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_rsp_q.push_back(apply_request(drive_item));
         if (!req_tvalid || req_tready) begin
            if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               drive_item = request_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {drive_item.line_levels, drive_item.write_value};
               req_tuser  <= {drive_item.reg_select, drive_item.command};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response ready, with the long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_count != 0) begin
         hold_count <= hold_count - 1;
         rsp_tready <= 1'b0;
      end else if (hold_seq != hold_seen) begin
         hold_seen  <= hold_seq;
         hold_count <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // response monitor
   always @(posedge clock) begin
      line_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("unexpected response", rsp_tdata[15:0], 16'h0);
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_tdata[15:0] !== want.read_value)
               report_mismatch("read_value", rsp_tdata[15:0], want.read_value);
            if (rsp_tdata[18:16] !== want.irq_groups)
               report_mismatch("irq_groups", 16'(rsp_tdata[18:16]), 16'(want.irq_groups));
            if (rsp_tdata[23:19] !== 5'd0)
               report_mismatch("padding", 16'(rsp_tdata[23:19]), 16'h0);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset values, unused command, levels ignored outside a sample
      push_req(eilc_pkg::CMD_READ,   eilc_pkg::REG_MASK,    16'h0000, 16'hffff);
      push_req(eilc_pkg::CMD_READ,   eilc_pkg::REG_RISING,  16'h0000, 16'hffff);
      push_req(eilc_pkg::CMD_READ,   eilc_pkg::REG_FALLING, 16'h0000, 16'hffff);
      push_req(eilc_pkg::CMD_READ,   eilc_pkg::REG_PENDING, 16'h0000, 16'hffff);
      push_req(CMD_UNUSED,           eilc_pkg::REG_PENDING, 16'hffff, 16'hffff);
      push_req(eilc_pkg::CMD_WRITE,  eilc_pkg::REG_RISING,  16'hffff, 16'hffff);
      push_req(eilc_pkg::CMD_WRITE,  eilc_pkg::REG_FALLING, 16'h5555, 16'h0000);
      // edges latch while masked
      push_req(eilc_pkg::CMD_SAMPLE, eilc_pkg::REG_MASK,    16'h0000, 16'hffff);
      push_req(eilc_pkg::CMD_READ,   eilc_pkg::REG_PENDING, 16'h0000, 16'h0000);
      push_req(eilc_pkg::CMD_WRITE,  eilc_pkg::REG_MASK,    16'h0003, 16'h0000);
      push_req(eilc_pkg::CMD_WRITE,  eilc_pkg::REG_MASK,    16'hfff0, 16'h0000);
      push_req(eilc_pkg::CMD_WRITE,  eilc_pkg::REG_MASK,    16'hffff, 16'h0000);
      push_req(eilc_pkg::CMD_WRITE,  eilc_pkg::REG_PENDING, 16'h0003, 16'h0000);
      push_req(eilc_pkg::CMD_WRITE,  eilc_pkg::REG_PENDING, 16'hffff, 16'h0000);
      // both edges selected on the even lines
      push_req(eilc_pkg::CMD_SAMPLE, eilc_pkg::REG_MASK,    16'h0000, 16'h0000);
      push_req(eilc_pkg::CMD_READ,   eilc_pkg::REG_PENDING, 16'h0000, 16'h0000);
      push_req(eilc_pkg::CMD_WRITE,  eilc_pkg::REG_PENDING, 16'hffff, 16'h0000);
      push_req(eilc_pkg::CMD_WRITE,  eilc_pkg::REG_RISING,  16'h0000, 16'h0000);
      push_req(eilc_pkg::CMD_SAMPLE, eilc_pkg::REG_MASK,    16'h0000, 16'hffff);
      push_req(eilc_pkg::CMD_SAMPLE, eilc_pkg::REG_MASK,    16'h0000, 16'h0004);
      push_req(eilc_pkg::CMD_READ,   eilc_pkg::REG_MASK,    16'h0000, 16'h0000);
      push_req(eilc_pkg::CMD_READ,   eilc_pkg::REG_FALLING, 16'h0000, 16'h0000);
      push_req(eilc_pkg::CMD_READ,   eilc_pkg::REG_RISING,  16'h0000, 16'h0000);
      push_req(eilc_pkg::CMD_WRITE,  eilc_pkg::REG_MASK,    16'h0000, 16'h0000);
      push_req(eilc_pkg::CMD_WRITE,  eilc_pkg::REG_FALLING, 16'h0000, 16'h0000);
      wait_drained();

      push_random(270);
      wait_drained();

      send_idle_pct <= 81;
      recv_idle_pct <= 27;
      push_random(270);
      wait_drained();

      // no idling; one long hold-off to back the block up
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      hold_seq      <= hold_seq + 1;
      push_random(260);
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_rsp_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
